// ===== rtl/core/cht_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, control word layout and microcode program of the hash table unit.
package cht_pkg;

	// Table geometry: a power of two, so the home slot is the low key bits
	localparam int TABLE_SIZE = 32;
	localparam int SLOT_W     = 5;
	localparam int KEY_W      = 31;
	localparam int ST_W       = 3;
	localparam int PC_W       = 5;

	// Result status codes
	localparam logic [ST_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [ST_W-1:0] ST_DUP      = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
	localparam logic [ST_W-1:0] ST_FOUND    = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
	localparam logic [ST_W-1:0] ST_INVALID  = 3'd5;

	// Slot pointer source
	typedef logic [2:0] pos_sel_t;
	localparam pos_sel_t P_HOLD = 3'd0;
	localparam pos_sel_t P_LOAD = 3'd1;
	localparam pos_sel_t P_ADV  = 3'd2;
	localparam pos_sel_t P_HOME = 3'd3;
	localparam pos_sel_t P_LINK = 3'd4;

	// Result slot source
	typedef logic [1:0] slot_sel_t;
	localparam slot_sel_t S_KEEP = 2'd0;
	localparam slot_sel_t S_POS  = 2'd1;
	localparam slot_sel_t S_ZERO = 2'd2;

	// Datapath action
	typedef logic [1:0] act_t;
	localparam act_t A_NONE  = 2'd0;
	localparam act_t A_PLACE = 2'd1;
	localparam act_t A_LINK  = 2'd2;
	localparam act_t A_EMIT  = 2'd3;

	// Jump conditions
	typedef logic [3:0] cond_t;
	localparam cond_t C_NEXT   = 4'd0;
	localparam cond_t C_ALWAYS = 4'd1;
	localparam cond_t C_NACC   = 4'd2;
	localparam cond_t C_KEYZ   = 4'd3;
	localparam cond_t C_FIND   = 4'd4;
	localparam cond_t C_EMPTY  = 4'd5;
	localparam cond_t C_HIT    = 4'd6;
	localparam cond_t C_NHOME  = 4'd7;
	localparam cond_t C_HOME   = 4'd8;
	localparam cond_t C_NOLINK = 4'd9;
	localparam cond_t C_NLAST  = 4'd10;
	localparam cond_t C_BUSY   = 4'd11;

	typedef logic [PC_W-1:0] pc_t;

	// One microcode word
	typedef struct packed {
		logic      rdy;
		pos_sel_t  pos_sel;
		slot_sel_t slot_sel;
		logic      st_we;
		logic [ST_W-1:0] st;
		act_t      act;
		cond_t     cond;
		pc_t       target;
	} ctrl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic in_acc;
		logic key_zero;
		logic find;
		logic empty;
		logic hit;
		logic at_home;
		logic link_vld;
		logic last;
		logic out_busy;
	} flags_t;

	// Program labels
	localparam pc_t L_WAIT   = 5'd0;
	localparam pc_t L_CHKZ   = 5'd1;
	localparam pc_t L_DISP   = 5'd2;
	localparam pc_t L_PROBE  = 5'd3;
	localparam pc_t L_PADV   = 5'd4;
	localparam pc_t L_PWRAP  = 5'd5;
	localparam pc_t L_FULL   = 5'd6;
	localparam pc_t L_PLACE  = 5'd7;
	localparam pc_t L_CHAIN  = 5'd8;
	localparam pc_t L_WALK   = 5'd9;
	localparam pc_t L_HOP    = 5'd10;
	localparam pc_t L_LINK   = 5'd11;
	localparam pc_t L_FIND   = 5'd12;
	localparam pc_t L_FADV   = 5'd13;
	localparam pc_t L_NF     = 5'd14;
	localparam pc_t L_FOUND  = 5'd15;
	localparam pc_t L_INV    = 5'd16;
	localparam pc_t L_DUP    = 5'd17;
	localparam pc_t L_EMIT   = 5'd18;
	localparam pc_t L_DONE   = 5'd19;

	// Microcode ROM: rdy, pos_sel, slot_sel, st_we, st, act, cond, target
	function automatic ctrl_t ucode_rom(input pc_t pc);
		ctrl_t w;
		w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE, C_ALWAYS, L_WAIT};
		unique case (pc)
			// wait for a transfer, point at the first slot to read
			L_WAIT:  w = ctrl_t'{1'b1, P_LOAD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_NACC, L_WAIT};
			L_CHKZ:  w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_KEYZ, L_INV};
			L_DISP:  w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_FIND, L_FIND};
			// insert: linear probe for duplicate or empty slot
			L_PROBE: w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_EMPTY, L_PLACE};
			L_PADV:  w = ctrl_t'{1'b0, P_ADV, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_HIT, L_DUP};
			L_PWRAP: w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_NHOME, L_PROBE};
			L_FULL:  w = ctrl_t'{1'b0, P_HOLD, S_ZERO, 1'b1, ST_FULL, A_NONE,
				C_ALWAYS, L_EMIT};
			// store the key; done if it landed at home
			L_PLACE: w = ctrl_t'{1'b0, P_HOLD, S_POS, 1'b1, ST_INSERTED, A_PLACE,
				C_HOME, L_EMIT};
			// walk the chain from home to its tail
			L_CHAIN: w = ctrl_t'{1'b0, P_HOME, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_NEXT, L_WAIT};
			L_WALK:  w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_NOLINK, L_LINK};
			L_HOP:   w = ctrl_t'{1'b0, P_LINK, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_ALWAYS, L_WALK};
			L_LINK:  w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_LINK,
				C_ALWAYS, L_EMIT};
			// find: scan from slot zero upward
			L_FIND:  w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_HIT, L_FOUND};
			L_FADV:  w = ctrl_t'{1'b0, P_ADV, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_NLAST, L_FIND};
			L_NF:    w = ctrl_t'{1'b0, P_HOLD, S_ZERO, 1'b1, ST_NOTFOUND, A_NONE,
				C_ALWAYS, L_EMIT};
			L_FOUND: w = ctrl_t'{1'b0, P_HOLD, S_POS, 1'b1, ST_FOUND, A_NONE,
				C_ALWAYS, L_EMIT};
			L_INV:   w = ctrl_t'{1'b0, P_HOLD, S_ZERO, 1'b1, ST_INVALID, A_NONE,
				C_ALWAYS, L_EMIT};
			L_DUP:   w = ctrl_t'{1'b0, P_HOLD, S_ZERO, 1'b1, ST_DUP, A_NONE,
				C_ALWAYS, L_EMIT};
			// hand the result to the output register
			L_EMIT:  w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_EMIT,
				C_BUSY, L_EMIT};
			L_DONE:  w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_ALWAYS, L_WAIT};
			default: w = ctrl_t'{1'b0, P_HOLD, S_KEEP, 1'b0, ST_INSERTED, A_NONE,
				C_ALWAYS, L_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/cht_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces of the hash table unit.
interface cht_req_if;
	logic                     valid;
	logic                     ready;
	logic                     mode;
	logic [cht_pkg::KEY_W-1:0] key;

	modport source (output valid, output mode, output key, input ready);
	modport sink   (input valid, input mode, input key, output ready);
endinterface

interface cht_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [cht_pkg::ST_W-1:0]   status;
	logic [cht_pkg::SLOT_W-1:0] slot;

	modport source (output valid, output status, output slot, input ready);
	modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== rtl/core/cht_useq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control ROM and conditional jumps.
module cht_useq (
	input  logic            clk,
	input  logic            arst_n,
	input  cht_pkg::flags_t flags,
	output cht_pkg::ctrl_t  ctrl
);
	import cht_pkg::*;

	pc_t  pc_q;
	logic take;

	assign ctrl = ucode_rom(pc_q);

	// jump condition select
	always_comb begin
		unique case (ctrl.cond)
			C_NEXT:   take = 1'b0;
			C_ALWAYS: take = 1'b1;
			C_NACC:   take = !flags.in_acc;
			C_KEYZ:   take = flags.key_zero;
			C_FIND:   take = flags.find;
			C_EMPTY:  take = flags.empty;
			C_HIT:    take = flags.hit;
			C_NHOME:  take = !flags.at_home;
			C_HOME:   take = flags.at_home;
			C_NOLINK: take = !flags.link_vld;
			C_NLAST:  take = !flags.last;
			C_BUSY:   take = flags.out_busy;
			default:  take = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= L_WAIT;
		end else if (take) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + pc_t'(1);
		end
	end

endmodule

// ===== rtl/core/cht_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: slot pointer, key and link memories, valid bits, result and output registers.
module cht_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  cht_pkg::ctrl_t  ctrl,
	output cht_pkg::flags_t flags,
	cht_req_if.sink         req,
	cht_rsp_if.source       rsp
);
	import cht_pkg::*;

	typedef logic [SLOT_W-1:0] slot_t;

	// stored table
	logic [KEY_W-1:0] key_mem [TABLE_SIZE];
	slot_t            link_mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0] used_q;
	logic [TABLE_SIZE-1:0] lvld_q;

	logic [KEY_W-1:0] key_q;
	logic             mode_q;
	slot_t            pos_q;
	slot_t            pos_next;
	slot_t            home;
	logic [KEY_W-1:0] rkey_q;
	slot_t            rlink_q;
	logic [KEY_W-1:0] eff_key;
	logic [ST_W-1:0]  res_status_q;
	slot_t            res_slot_q;
	logic             out_valid_q;
	logic [ST_W-1:0]  out_status_q;
	slot_t            out_slot_q;
	logic             in_acc;
	logic             out_busy;
	logic             do_emit;

	assign req.ready = ctrl.rdy;
	assign in_acc    = req.valid && ctrl.rdy;
	assign home      = key_q[SLOT_W-1:0];
	assign out_busy  = out_valid_q && !rsp.ready;
	assign do_emit   = (ctrl.act == A_EMIT) && !out_busy;

	// next slot pointer; also the read address of both memories
	always_comb begin
		unique case (ctrl.pos_sel)
			P_HOLD:  pos_next = pos_q;
			P_LOAD:  pos_next = req.mode ? slot_t'(0) : req.key[SLOT_W-1:0];
			P_ADV:   pos_next = (pos_q == slot_t'(TABLE_SIZE - 1)) ? slot_t'(0)
				: pos_q + slot_t'(1);
			P_HOME:  pos_next = home;
			P_LINK:  pos_next = rlink_q;
			default: pos_next = pos_q;
		endcase
	end

	// an unused slot reads as empty
	assign eff_key = used_q[pos_q] ? rkey_q : '0;

	always_comb begin
		flags.in_acc   = in_acc;
		flags.key_zero = (key_q == '0);
		flags.find     = mode_q;
		flags.empty    = (eff_key == '0);
		flags.hit      = used_q[pos_q] && (rkey_q == key_q);
		flags.at_home  = (pos_q == home);
		flags.link_vld = lvld_q[pos_q];
		flags.last     = (pos_q == slot_t'(TABLE_SIZE - 1));
		flags.out_busy = out_busy;
	end

	// memories: one write port, registered read at pos_next
	always_ff @(posedge clk) begin
		if (ctrl.act == A_PLACE) begin
			key_mem[pos_q] <= key_q;
		end
		if (ctrl.act == A_LINK) begin
			link_mem[pos_q] <= res_slot_q;
		end
		rkey_q  <= key_mem[pos_next];
		rlink_q <= link_mem[pos_next];
	end

	// request capture and pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q  <= '0;
			mode_q <= 1'b0;
			pos_q  <= '0;
		end else begin
			pos_q <= pos_next;
			if (in_acc) begin
				key_q  <= req.key;
				mode_q <= req.mode;
			end
		end
	end

	// per-slot valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			lvld_q <= '0;
		end else if (ctrl.act == A_PLACE) begin
			used_q[pos_q] <= 1'b1;
			lvld_q[pos_q] <= 1'b0;
		end else if (ctrl.act == A_LINK) begin
			lvld_q[pos_q] <= 1'b1;
		end
	end

	// result being built
	always_ff @(posedge clk) begin
		if (ctrl.st_we) begin
			res_status_q <= ctrl.st;
		end
		case (ctrl.slot_sel)
			S_POS:   res_slot_q <= pos_q;
			S_ZERO:  res_slot_q <= '0;
			default: res_slot_q <= res_slot_q;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_slot_q   <= '0;
		end else if (do_emit) begin
			out_valid_q  <= 1'b1;
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.slot   = out_slot_q;

endmodule

// ===== rtl/core/coalesced_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Top level of the coalesced-chaining hash table unit.
//
//   channel  role   payload            transfer when
//   req      sink   mode, key          req.valid && req.ready
//   rsp      source status, slot       rsp.valid && rsp.ready
//
// One request at a time; ready returns by way of L_DONE after the result is loaded.
// Insert: probes occupied slots from home; off home, the new slot is then linked to the
// chain tail found from home. Duplicate: a hit while probing; full table: back at home.
//   Find: scans from slot zero to the hit, or the last slot for a miss; the one read port reads a slot a step.
// Reset clears the slot valid bits at once; the table is usable right away.
// A result waits in the output register; the next request is taken meanwhile.
module coalesced_hash_table_unit (
	input logic       clk,
	input logic       arst_n,
	cht_req_if.sink   req,
	cht_rsp_if.source rsp
);
	import cht_pkg::*;

	ctrl_t  ctrl;
	flags_t flags;

	cht_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	cht_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.flags  (flags),
		.req    (req),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	// a new request is never taken in the cycle after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request taken back to back");

	// only inserted and found results carry a slot
	a_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.status != ST_INSERTED) && (rsp.status != ST_FOUND))
		|-> (rsp.slot == '0))
		else $error("slot set on a result without one");

	// status stays within the defined codes
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status <= ST_INVALID))
		else $error("undefined status code");
`endif

endmodule
